/* hw/rtl/linear_rgb_to_xyb_assert.svh */
// assertion macros for the linear rgb to xyb block
// no dependencies; included by files that check their own logic
`ifndef LINEAR_RGB_TO_XYB_ASSERT_SVH
`define LINEAR_RGB_TO_XYB_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define LRX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lrx assertion failed");
// next-cycle implication, disabled in reset
`define LRX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lrx assertion failed");
`else
`define LRX_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LRX_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/lrx_pkg.sv */
// shared types and constants for the linear rgb to xyb transform
// no dependencies; used by linear_rgb_to_xyb
package lrx_pkg;

    localparam int FRAC_BITS = 12;
    localparam int PIX_W     = 16;
    localparam int COEF_W    = 18;
    localparam int REG_W     = 3 * COEF_W;
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 6;
    localparam int OUT_W     = 20;
    localparam int MIX_W     = 24;
    localparam int PROD_W    = COEF_W + PIX_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int N_W       = MIX_W + 2 * FRAC_BITS;
    localparam int ROOT_W    = (N_W + 2) / 3;
    localparam int CUBE_W    = N_W + 2;
    localparam int SQ_W      = 2 * ROOT_W;
    localparam int SUM_W     = 24;
    // input, product, sum, clamp, one stage per root bit, output
    localparam int DEPTH     = 5 + ROOT_W;

    typedef enum logic [2:0] {
        REG_ROW_ZERO,
        REG_ROW_ONE,
        REG_ROW_TWO,
        REG_BIAS,
        REG_OFFSET
    } t_reg_idx;

    typedef struct packed {
        logic signed [PIX_W-1:0] red;
        logic signed [PIX_W-1:0] green;
        logic signed [PIX_W-1:0] blue;
        logic                    row_end_in;
    } t_rgb_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] x_value;
        logic signed [OUT_W-1:0] y_value;
        logic signed [OUT_W-1:0] z_value;
        logic                    saturated;
        logic                    row_end_out;
    } t_xyb_out;

    typedef struct packed {
        logic [ROOT_W-1:0] r;
        logic [SQ_W-1:0]   r2;
        logic [CUBE_W-1:0] r3;
    } t_root_lane;

    // signed field of a packed register
    function automatic logic signed [COEF_W-1:0] field(input logic [REG_W-1:0] w,
                                                       input int idx);
        return w[COEF_W*idx +: COEF_W];
    endfunction

    // saturate to the output range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((1 <<< (OUT_W - 1)) - 1);
        lo = -SUM_W'(1 <<< (OUT_W - 1));
        if (v > hi) return hi[OUT_W-1:0];
        if (v < lo) return lo[OUT_W-1:0];
        return v[OUT_W-1:0];
    endfunction

endpackage

/* hw/rtl/linear_rgb_to_xyb.sv */
// linear rgb to xyb opsin transform, pipelined, with apb register port
// depends on lrx_pkg and linear_rgb_to_xyb_assert.svh
//
//  channel | signals                              | direction
//  pixel   | i_valid, o_stall, i_pixel            | in
//  xyb     | o_valid, i_stall, o_xyb              | out
//  config  | psel penable pwrite paddr pwdata ... | apb
//
// one pixel per cycle unless the full pipe is stalled (one stage per cube root bit, 16)
// each stage holds while the stage after it is full and stalled, so bubbles
// are squeezed out and the input stalls only when every stage is occupied
// synchronous active-low reset clears valid bits and the registers
`include "linear_rgb_to_xyb_assert.svh"
module linear_rgb_to_xyb (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  lrx_pkg::t_rgb_in            i_pixel,
    output logic                        o_valid,
    input  logic                        i_stall,
    output lrx_pkg::t_xyb_out           o_xyb,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lrx_pkg::ADDR_W-1:0]  paddr,
    input  logic [lrx_pkg::DATA_W-1:0]  pwdata,
    output logic [lrx_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import lrx_pkg::*;

    // configuration registers
    logic [REG_W-1:0] r_row [0:2];
    logic [REG_W-1:0] r_bias;
    logic [REG_W-1:0] r_offset;
    t_reg_idx         n_idx;

    assign n_idx  = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= '0;
            r_row[1] <= '0;
            r_row[2] <= '0;
            r_bias   <= '0;
            r_offset <= '0;
        end else if (psel && penable && pwrite) begin
            case (n_idx)
                REG_ROW_ZERO: r_row[0] <= pwdata[REG_W-1:0];
                REG_ROW_ONE:  r_row[1] <= pwdata[REG_W-1:0];
                REG_ROW_TWO:  r_row[2] <= pwdata[REG_W-1:0];
                REG_BIAS:     r_bias   <= pwdata[REG_W-1:0];
                REG_OFFSET:   r_offset <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        case (n_idx)
            REG_ROW_ZERO: prdata = DATA_W'(r_row[0]);
            REG_ROW_ONE:  prdata = DATA_W'(r_row[1]);
            REG_ROW_TWO:  prdata = DATA_W'(r_row[2]);
            REG_BIAS:     prdata = DATA_W'(r_bias);
            REG_OFFSET:   prdata = DATA_W'(r_offset);
            default:      prdata = '0;
        endcase
    end

    // valid bits and per-stage advance
    logic [DEPTH-1:0] r_vld;
    logic [DEPTH:0]   n_adv;
    logic [1:0]       r_side [0:DEPTH-2]; // {saturated, row end}

    assign n_adv[DEPTH] = !i_stall;
    assign o_stall      = !n_adv[0];
    assign o_valid      = r_vld[DEPTH-1];

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_ctl
            assign n_adv[k] = !r_vld[k] || n_adv[k+1];
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (n_adv[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    endgenerate

    // stage 0: input register
    logic signed [PIX_W-1:0] r_px [0:2];
    always_ff @(posedge i_clk) begin
        if (n_adv[0]) begin
            r_px[0]   <= i_pixel.red;
            r_px[1]   <= i_pixel.green;
            r_px[2]   <= i_pixel.blue;
            r_side[0] <= {1'b0, i_pixel.row_end_in};
        end
    end

    // stage 1: nine products and the scaled biases
    logic signed [PROD_W-1:0] r_prod [0:2][0:2];
    logic signed [ACC_W-1:0]  r_bsh  [0:2];
    always_ff @(posedge i_clk) begin
        if (n_adv[1]) begin
            for (int m = 0; m < 3; m++) begin
                for (int i = 0; i < 3; i++) begin
                    r_prod[m][i] <= field(r_row[m], i) * r_px[i];
                end
                r_bsh[m] <= ACC_W'(field(r_bias, m)) <<< FRAC_BITS;
            end
            r_side[1] <= r_side[0];
        end
    end

    // stage 2: accumulate each mix
    logic signed [ACC_W-1:0] r_acc [0:2];
    always_ff @(posedge i_clk) begin
        if (n_adv[2]) begin
            for (int m = 0; m < 3; m++) begin
                r_acc[m] <= ACC_W'(r_prod[m][0]) + ACC_W'(r_prod[m][1])
                          + ACC_W'(r_prod[m][2]) + r_bsh[m];
            end
            r_side[2] <= r_side[1];
        end
    end

    // stage 3: floor, clamp at zero and saturate
    logic [MIX_W-1:0]        r_mix [0:2];
    logic signed [ACC_W-1:0] n_shr [0:2];
    logic [MIX_W-1:0]        n_mix [0:2];
    logic [2:0]              n_sat;
    always_comb begin
        for (int m = 0; m < 3; m++) begin
            n_shr[m] = r_acc[m] >>> FRAC_BITS;
            n_sat[m] = 1'b0;
            if (r_acc[m] <= 0) begin
                n_mix[m] = '0;
            end else if (n_shr[m] > ACC_W'({MIX_W{1'b1}})) begin
                n_mix[m] = '1;
                n_sat[m] = 1'b1;
            end else begin
                n_mix[m] = n_shr[m][MIX_W-1:0];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (n_adv[3]) begin
            for (int m = 0; m < 3; m++) r_mix[m] <= n_mix[m];
            r_side[3] <= {|n_sat, r_side[2][0]};
        end
    end

    // stages 4 and up: cube root, one bit per stage, msb first
    t_root_lane       r_lane [0:ROOT_W-1][0:2];
    logic [MIX_W-1:0] r_rmix [0:ROOT_W-1][0:2];

    genvar j, q;
    generate
        for (j = 0; j < ROOT_W; j++) begin : g_root
            localparam int B = ROOT_W - 1 - j;
            for (q = 0; q < 3; q++) begin : g_lane
                t_root_lane       n_prev;
                logic [MIX_W-1:0] n_pmix;
                logic [CUBE_W-1:0] n_a;
                logic [CUBE_W-1:0] n_c;
                logic [CUBE_W-1:0] n_t3;
                logic [SQ_W-1:0]   n_t2;
                logic [CUBE_W-1:0] n_n;
                if (j == 0) begin : g_first
                    assign n_prev = '0;
                    assign n_pmix = r_mix[q];
                end else begin : g_next
                    assign n_prev = r_lane[(j == 0) ? 0 : j - 1][q];
                    assign n_pmix = r_rmix[(j == 0) ? 0 : j - 1][q];
                end
                // (r + d)^3 = r^3 + 3 r^2 d + 3 r d^2 + d^3 with d = 2^B
                assign n_a  = CUBE_W'(n_prev.r2) << B;
                assign n_c  = CUBE_W'(n_prev.r) << (2 * B);
                assign n_t3 = n_prev.r3 + n_a + (n_a << 1) + n_c + (n_c << 1)
                            + (CUBE_W'(1) << (3 * B));
                assign n_t2 = n_prev.r2 + (SQ_W'(n_prev.r) << (B + 1))
                            + (SQ_W'(1) << (2 * B));
                assign n_n  = CUBE_W'({n_pmix, {(2 * FRAC_BITS){1'b0}}});
                always_ff @(posedge i_clk) begin
                    if (n_adv[4 + j]) begin
                        r_rmix[j][q] <= n_pmix;
                        if (n_t3 <= n_n) begin
                            r_lane[j][q].r  <= n_prev.r | (ROOT_W'(1) << B);
                            r_lane[j][q].r2 <= n_t2;
                            r_lane[j][q].r3 <= n_t3;
                        end else begin
                            r_lane[j][q] <= n_prev;
                        end
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                if (n_adv[4 + j]) r_side[4 + j] <= r_side[3 + j];
            end
        end
    endgenerate

    // output stage: offsets, half difference and half sum
    logic signed [SUM_W-1:0] n_s [0:2];
    logic signed [SUM_W-1:0] n_dif;
    logic signed [SUM_W-1:0] n_sum;
    always_comb begin
        for (int m = 0; m < 3; m++) begin
            n_s[m] = SUM_W'(r_lane[ROOT_W-1][m].r) + SUM_W'(field(r_offset, m));
        end
        n_dif = (n_s[0] - n_s[1]) >>> 1;
        n_sum = (n_s[0] + n_s[1]) >>> 1;
    end
    always_ff @(posedge i_clk) begin
        if (n_adv[DEPTH-1]) begin
            o_xyb.x_value     <= sat_out(n_dif);
            o_xyb.y_value     <= sat_out(n_sum);
            o_xyb.z_value     <= sat_out(n_s[2]);
            o_xyb.saturated   <= r_side[DEPTH-2][1];
            o_xyb.row_end_out <= r_side[DEPTH-2][0];
        end
    end

    // input is held back only when the whole pipe is full and the output stalls
    `LRX_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_stall, (&r_vld) && i_stall)
    // a finished root in the first lane never cubes above its radicand
    `LRX_ASSERT_NOW(a_root_bound, i_clk, i_rst_n, r_vld[DEPTH-2],
        r_lane[ROOT_W-1][0].r3 <= CUBE_W'({r_rmix[ROOT_W-1][0], {(2 * FRAC_BITS){1'b0}}}))
    // the saturation flag only goes with a mix pinned at full scale
    `LRX_ASSERT_NOW(a_sat_mix, i_clk, i_rst_n, r_vld[3] && r_side[3][1],
        (&r_mix[0]) || (&r_mix[1]) || (&r_mix[2]))

endmodule
